/* sv/srlp_pkg.sv */
`default_nettype none
package srlp_pkg;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_TYPE  = 3'd1;
	localparam logic [2:0] PH_COUNT = 3'd2;
	localparam logic [2:0] PH_ADDR  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_CSUM  = 3'd5;
	localparam logic [2:0] PH_TRAIL = 3'd6;

	localparam logic [2:0] EV_TYPE_ERR  = 3'd0;
	localparam logic [2:0] EV_COUNT_ERR = 3'd1;
	localparam logic [2:0] EV_HEADER    = 3'd2;
	localparam logic [2:0] EV_DATA      = 3'd3;
	localparam logic [2:0] EV_CSUM      = 3'd4;

	localparam logic [0:0] REG_MAX_COUNT     = 1'd0;
	localparam logic [0:0] REG_TRAILER_CHARS = 1'd1;

	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;

	localparam logic [7:0] MAX_COUNT_RESET = 8'd255;
	localparam logic [1:0] TRAILER_RESET   = 2'd2;

	// address bytes carried by each record type
	function automatic logic [2:0] addr_bytes(input logic [3:0] rtype);
		logic [2:0] r;
		case (rtype)
			4'd2, 4'd6, 4'd8: r = 3'd3;
			4'd3, 4'd7:       r = 3'd4;
			4'd4:             r = 3'd0;
			default:          r = 3'd2;
		endcase
		return r;
	endfunction

	// bit 4 flags a character that is not a hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] t;
		logic [4:0] r;
		t = 8'd0;
		if (c >= CH_0 && c <= CH_9) begin
			t = c - CH_0;
			r = {1'b0, t[3:0]};
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			t = c - CH_UP_A + 8'd10;
			r = {1'b0, t[3:0]};
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			t = c - CH_LO_A + 8'd10;
			r = {1'b0, t[3:0]};
		end else begin
			r = 5'b10000;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/srecord_line_parser.sv */
`default_nettype none
// S-record parser, one ASCII character per transfer. Each character goes into an input
// register and is decoded by one short pass of logic into the parser state and an output
// register, so one character is taken every clock while results keep flowing; the output
// register decouples the two channels. A character produces at most one event: type
// error, count error, header (with the address), data byte, or checksum (not verified).
// After a bad type or count the parser restarts at the next character. Users must write
// max_count, trailer_chars (plain write port) only while the parser is idle, not enforced.
module srecord_line_parser
	import srlp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ascii_char,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       event_kind,
	output logic [3:0]       record_type,
	output logic [7:0]       byte_count,
	output logic [31:0]      load_address,
	output logic [3:0]       address_chars,
	output logic [7:0]       data_value,
	output logic             bad_hex
);

	logic [7:0]  max_count_q;
	logic [1:0]  trailer_q;

	logic        valid_s1;
	logic [7:0]  char_s1;

	logic [2:0]  phase_q;
	logic [7:0]  first_q;
	logic [3:0]  idx_q;
	logic [3:0]  type_q;
	logic [7:0]  count_q;
	logic [31:0] acc_q;
	logic [7:0]  pairs_q;
	logic        hexerr_q;

	logic [2:0]  phase_d;
	logic [7:0]  first_d;
	logic [3:0]  idx_d;
	logic [3:0]  type_d;
	logic [7:0]  count_d;
	logic [31:0] acc_d;
	logic [7:0]  pairs_d;
	logic        hexerr_d;

	logic        emit;
	logic        zero_all;
	logic        do_restart;
	logic        new_record;
	logic [2:0]  kind;
	logic [31:0] addr_v;
	logic [7:0]  data_v;
	logic [4:0]  nib_r;
	logic        hexerr_n;
	logic [7:0]  acc8;
	logic [2:0]  ab_cur;
	logic [2:0]  ab_new;
	logic [3:0]  idx_inc;

	logic        advance;
	logic        process;

	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [3:0]  type_out_q;
	logic [7:0]  count_out_q;
	logic [31:0] addr_out_q;
	logic [3:0]  achars_q;
	logic [7:0]  data_out_q;
	logic        bad_q;

	assign advance  = !out_valid_q || out_ready;
	assign process  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= MAX_COUNT_RESET;
			trailer_q   <= TRAILER_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAX_COUNT:     max_count_q <= cfg_data;
				REG_TRAILER_CHARS: trailer_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= ascii_char;
		end
	end

	assign nib_r    = hex_nibble(char_s1);
	assign hexerr_n = hexerr_q | nib_r[4];
	assign acc8     = {acc_q[3:0], nib_r[3:0]};
	assign ab_cur   = addr_bytes(type_q);
	assign idx_inc  = idx_q + 4'd1;

	always_comb begin
		phase_d    = phase_q;
		first_d    = first_q;
		idx_d      = idx_q;
		type_d     = type_q;
		count_d    = count_q;
		acc_d      = acc_q;
		pairs_d    = pairs_q;
		hexerr_d   = hexerr_q;
		emit       = 1'b0;
		zero_all   = 1'b0;
		do_restart = 1'b0;
		new_record = 1'b0;
		kind       = EV_TYPE_ERR;
		addr_v     = 32'd0;
		data_v     = 8'd0;
		case (phase_q)
			PH_TYPE: begin
				if (first_q != CH_S || char_s1 < CH_0 || char_s1 > CH_9 ||
						char_s1 == CH_4) begin
					emit       = 1'b1;
					zero_all   = 1'b1;
					kind       = EV_TYPE_ERR;
					do_restart = 1'b1;
				end else begin
					type_d   = char_s1[3:0];
					hexerr_d = 1'b0;
					acc_d    = 32'd0;
					idx_d    = 4'd0;
					phase_d  = PH_COUNT;
				end
			end
			PH_COUNT: begin
				hexerr_d = hexerr_n;
				acc_d    = {24'd0, acc8};
				idx_d    = idx_inc;
				if (idx_inc >= 4'd2) begin
					count_d = acc8;
					if (acc8 == 8'd0 || acc8 > max_count_q ||
							acc8 < ({5'd0, ab_cur} + 8'd1)) begin
						emit       = 1'b1;
						kind       = EV_COUNT_ERR;
						do_restart = 1'b1;
					end else begin
						acc_d   = 32'd0;
						idx_d   = 4'd0;
						phase_d = PH_ADDR;
					end
				end
			end
			PH_ADDR: begin
				hexerr_d = hexerr_n;
				acc_d    = {acc_q[27:0], nib_r[3:0]};
				idx_d    = idx_inc;
				if (idx_inc >= {ab_cur, 1'b0}) begin
					emit    = 1'b1;
					kind    = EV_HEADER;
					addr_v  = {acc_q[27:0], nib_r[3:0]};
					pairs_d = count_q - {5'd0, ab_cur} - 8'd1;
					acc_d   = 32'd0;
					idx_d   = 4'd0;
					phase_d = (pairs_d == 8'd0) ? PH_CSUM : PH_DATA;
				end
			end
			PH_DATA: begin
				hexerr_d = hexerr_n;
				acc_d    = {24'd0, acc8};
				idx_d    = idx_inc;
				if (idx_inc >= 4'd2) begin
					emit    = 1'b1;
					kind    = EV_DATA;
					data_v  = acc8;
					pairs_d = pairs_q - 8'd1;
					acc_d   = 32'd0;
					idx_d   = 4'd0;
					if (pairs_d == 8'd0) begin
						phase_d = PH_CSUM;
					end
				end
			end
			PH_CSUM: begin
				hexerr_d = hexerr_n;
				acc_d    = {24'd0, acc8};
				idx_d    = idx_inc;
				if (idx_inc >= 4'd2) begin
					emit   = 1'b1;
					kind   = EV_CSUM;
					data_v = acc8;
					acc_d  = 32'd0;
					idx_d  = 4'd0;
					if (trailer_q == 2'd0) begin
						do_restart = 1'b1;
					end else begin
						phase_d = PH_TRAIL;
					end
				end
			end
			PH_TRAIL: begin
				idx_d = idx_inc;
				// trailer length is read live, a lowered value ends the skip at once
				if (idx_inc >= {2'd0, trailer_q}) begin
					do_restart = 1'b1;
				end
			end
			default: begin
				do_restart = 1'b1;
				new_record = 1'b1;
			end
		endcase
	end

	assign ab_new = addr_bytes(type_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			first_q  <= 8'd0;
			idx_q    <= 4'd0;
			type_q   <= 4'd0;
			count_q  <= 8'd0;
			acc_q    <= 32'd0;
			pairs_q  <= 8'd0;
			hexerr_q <= 1'b0;
		end else if (process) begin
			if (do_restart) begin
				phase_q  <= new_record ? PH_TYPE : PH_START;
				first_q  <= new_record ? char_s1 : 8'd0;
				idx_q    <= 4'd0;
				type_q   <= 4'd0;
				count_q  <= 8'd0;
				acc_q    <= 32'd0;
				pairs_q  <= 8'd0;
				hexerr_q <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				first_q  <= first_d;
				idx_q    <= idx_d;
				type_q   <= type_d;
				count_q  <= count_d;
				acc_q    <= acc_d;
				pairs_q  <= pairs_d;
				hexerr_q <= hexerr_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	// event fields reflect the record before any restart
	always_ff @(posedge clk) begin
		if (process && emit) begin
			kind_q      <= kind;
			type_out_q  <= zero_all ? 4'd0 : type_d;
			count_out_q <= zero_all ? 8'd0 : count_d;
			addr_out_q  <= addr_v;
			achars_q    <= zero_all ? 4'd0 : {ab_new, 1'b0};
			data_out_q  <= data_v;
			bad_q       <= zero_all ? 1'b0 : hexerr_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = kind_q;
	assign record_type   = type_out_q;
	assign byte_count    = count_out_q;
	assign load_address  = addr_out_q;
	assign address_chars = achars_q;
	assign data_value    = data_out_q;
	assign bad_hex       = bad_q;

`ifndef SYNTHESIS
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_kind <= EV_CSUM))
		else $error("event kind out of range");

	a_type_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == EV_TYPE_ERR) |->
		(record_type == 4'd0 && byte_count == 8'd0 && address_chars == 4'd0 &&
		 load_address == 32'd0 && data_value == 8'd0 && !bad_hex))
		else $error("type error event carries fields");

	a_addr_chars: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind != EV_TYPE_ERR) |->
		(address_chars == 4'd4 || address_chars == 4'd6 || address_chars == 4'd8))
		else $error("bad address width");

	a_trail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TRAIL) |-> (idx_q < 4'd3))
		else $error("trailer skip overran");
`endif

endmodule
`default_nettype wire

/* tb/sv/srecord_line_parser_tb.sv */
module srecord_line_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import srlp_pkg::*;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  rtype;
		logic [7:0]  count;
		logic [31:0] addr;
		logic [3:0]  achars;
		logic [7:0]  data;
		logic        bad;
	} parse_event_t;

	typedef struct packed {
		logic [7:0]   ch;
		logic         typed;
		parse_event_t ev;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [0:0]  cfg_index = REG_MAX_COUNT;
	logic [7:0]  cfg_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  ascii_char = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_kind;
	logic [3:0]  record_type;
	logic [7:0]  byte_count;
	logic [31:0] load_address;
	logic [3:0]  address_chars;
	logic [7:0]  data_value;
	logic        bad_hex;

	srecord_line_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.ascii_char    (ascii_char),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.record_type   (record_type),
		.byte_count    (byte_count),
		.load_address  (load_address),
		.address_chars (address_chars),
		.data_value    (data_value),
		.bad_hex       (bad_hex)
	);

	always #6 clk = ~clk;

	// parser shadow state and register copies
	logic [2:0]  pr_phase = PH_START;
	logic [7:0]  pr_first = 8'd0;
	logic [8:0]  pr_index = 9'd0;
	logic [3:0]  pr_type = 4'd0;
	logic [7:0]  pr_count = 8'd0;
	logic [31:0] pr_acc = 32'd0;
	logic [7:0]  pr_left = 8'd0;
	logic        pr_hexerr = 1'b0;
	logic [7:0]  cfg_max_count = MAX_COUNT_RESET;
	logic [1:0]  cfg_trailer = TRAILER_RESET;

	parse_event_t event_q[$];
	logic [7:0]   line_q[$];
	stim_row_t    dir_rows [0:19];

	int unsigned burst_left = 0;
	int unsigned rx_mode = 0;
	int unsigned rx_left = 0;
	int unsigned mismatches = 0;
	int unsigned chars_sent = 0;
	int unsigned events_seen = 0;
	int unsigned records_built = 0;
	int unsigned settings_used = 0;

	function automatic int unsigned addr_len(input logic [3:0] t);
		case (t)
			4'd2, 4'd6, 4'd8: return 3;
			4'd3, 4'd7:       return 4;
			4'd4:             return 0;
			default:          return 2;
		endcase
	endfunction

	function automatic logic [3:0] nibble_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return c[3:0];
		if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F))
			return c[3:0] + 4'd9;
		pr_hexerr = 1'b1;
		return 4'd0;
	endfunction

	function automatic void clear_parser();
		pr_phase = PH_START;
		pr_first = 8'd0;
		pr_index = 9'd0;
		pr_type = 4'd0;
		pr_count = 8'd0;
		pr_acc = 32'd0;
		pr_left = 8'd0;
		pr_hexerr = 1'b0;
	endfunction

	function automatic parse_event_t record_event(input logic [2:0] kind, input logic [31:0] addr,
			input logic [7:0] data);
		parse_event_t ev;
		ev.kind = kind;
		ev.rtype = pr_type;
		ev.count = pr_count;
		ev.addr = addr;
		ev.achars = 4'(addr_len(pr_type) * 2);
		ev.data = data;
		ev.bad = pr_hexerr;
		return ev;
	endfunction

	function automatic parse_event_t mk_ev(input logic [2:0] kind, input logic [3:0] rtype,
			input logic [7:0] count, input logic [31:0] addr, input logic [3:0] achars,
			input logic [7:0] data, input logic bad);
		parse_event_t ev;
		ev = '{kind, rtype, count, addr, achars, data, bad};
		return ev;
	endfunction

	function automatic bit predict_char(input logic [7:0] c, output parse_event_t ev);
		logic [3:0] n;
		bit hit;
		ev = '0;
		hit = 1'b0;
		case (pr_phase)
			PH_TYPE: begin
				if (pr_first != CH_S || c < CH_0 || c > CH_9 || c == CH_4) begin
					clear_parser();
					ev.kind = EV_TYPE_ERR;
					hit = 1'b1;
				end else begin
					pr_type = c[3:0];
					pr_hexerr = 1'b0;
					pr_acc = 32'd0;
					pr_index = 9'd0;
					pr_phase = PH_COUNT;
				end
			end
			PH_COUNT: begin
				n = nibble_value(c);
				pr_acc = {24'd0, pr_acc[3:0], n};
				pr_index = pr_index + 9'd1;
				if (pr_index >= 9'd2) begin
					pr_count = pr_acc[7:0];
					if (pr_count == 8'd0 || pr_count > cfg_max_count ||
							pr_count < addr_len(pr_type) + 1) begin
						ev = record_event(EV_COUNT_ERR, 32'd0, 8'd0);
						hit = 1'b1;
						clear_parser();
					end else begin
						pr_acc = 32'd0;
						pr_index = 9'd0;
						pr_phase = PH_ADDR;
					end
				end
			end
			PH_ADDR: begin
				n = nibble_value(c);
				pr_acc = {pr_acc[27:0], n};
				pr_index = pr_index + 9'd1;
				if (pr_index >= addr_len(pr_type) * 2) begin
					ev = record_event(EV_HEADER, pr_acc, 8'd0);
					hit = 1'b1;
					pr_left = 8'(pr_count - addr_len(pr_type) - 1);
					pr_acc = 32'd0;
					pr_index = 9'd0;
					pr_phase = (pr_left == 8'd0) ? PH_CSUM : PH_DATA;
				end
			end
			PH_DATA: begin
				n = nibble_value(c);
				pr_acc = {24'd0, pr_acc[3:0], n};
				pr_index = pr_index + 9'd1;
				if (pr_index >= 9'd2) begin
					ev = record_event(EV_DATA, 32'd0, pr_acc[7:0]);
					hit = 1'b1;
					pr_left = pr_left - 8'd1;
					pr_acc = 32'd0;
					pr_index = 9'd0;
					if (pr_left == 8'd0)
						pr_phase = PH_CSUM;
				end
			end
			PH_CSUM: begin
				n = nibble_value(c);
				pr_acc = {24'd0, pr_acc[3:0], n};
				pr_index = pr_index + 9'd1;
				if (pr_index >= 9'd2) begin
					ev = record_event(EV_CSUM, 32'd0, pr_acc[7:0]);
					hit = 1'b1;
					pr_acc = 32'd0;
					pr_index = 9'd0;
					if (cfg_trailer == 2'd0)
						clear_parser();
					else
						pr_phase = PH_TRAIL;
				end
			end
			PH_TRAIL: begin
				// line end characters are skipped without looking at them
				pr_index = pr_index + 9'd1;
				if (pr_index >= {7'd0, cfg_trailer})
					clear_parser();
			end
			default: begin
				clear_parser();
				pr_first = c;
				pr_phase = PH_TYPE;
			end
		endcase
		return hit;
	endfunction

	// hex digit in random case, now and then a character that is not hex
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10)
			c = CH_0 + n;
		else
			c = ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + n - 8'd10;
		if ($urandom_range(0, 79) == 0) begin
			do
				c = 8'($urandom_range(0, 255));
			while ((c >= CH_0 && c <= CH_9) || (c >= CH_UP_A && c <= CH_UP_F) ||
				(c >= CH_LO_A && c <= CH_LO_F));
		end
		return c;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		line_q.push_back(hex_char(b[7:4]));
		line_q.push_back(hex_char(b[3:0]));
	endtask

	task automatic build_record();
		int unsigned pick, ab, maxd, nd, tl, v;
		int i;
		logic [3:0]  t;
		logic [31:0] addr;
		logic [7:0]  cnt, b, sum, c;
		pick = $urandom_range(0, 99);
		v = $urandom_range(0, 8);
		t = 4'((v >= 4) ? v + 1 : v);
		ab = addr_len(t);
		records_built++;
		if (pick < 80) begin
			maxd = (cfg_max_count >= ab + 1) ? cfg_max_count - ab - 1 : 0;
			if ($urandom_range(0, 29) == 0)
				nd = $urandom_range(0, maxd);
			else
				nd = $urandom_range(0, (maxd < 6) ? maxd : 6);
			cnt = 8'(ab + 1 + nd);
			line_q.push_back(CH_S);
			line_q.push_back(CH_0 + t);
			push_byte(cnt);
			case ($urandom_range(0, 7))
				0:       addr = '1;
				1:       addr = '0;
				default: addr = $urandom();
			endcase
			sum = cnt;
			for (i = int'(ab) - 1; i >= 0; i--) begin
				b = addr[8 * i +: 8];
				push_byte(b);
				sum = sum + b;
			end
			repeat (nd) begin
				case ($urandom_range(0, 7))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				push_byte(b);
				sum = sum + b;
			end
			push_byte(~sum);
			// sometimes a line end of the wrong length throws the framing off
			tl = cfg_trailer;
			if ($urandom_range(0, 19) == 0)
				tl = $urandom_range(0, 3);
			for (i = 0; i < int'(tl); i++) begin
				if ($urandom_range(0, 3) == 0)
					line_q.push_back(8'($urandom_range(0, 255)));
				else
					line_q.push_back((i == int'(tl) - 1) ? 8'h0A : 8'h0D);
			end
		end else if (pick < 88) begin
			case ($urandom_range(0, 2))
				0:       cnt = 8'd0;
				1:       cnt = 8'($urandom_range(1, ab));
				default: cnt = (cfg_max_count < 8'd255) ?
					8'($urandom_range(cfg_max_count + 1, 255)) : 8'(ab);
			endcase
			line_q.push_back(CH_S);
			line_q.push_back(CH_0 + t);
			push_byte(cnt);
		end else if (pick < 94) begin
			if ($urandom_range(0, 1)) begin
				line_q.push_back(CH_S);
				if ($urandom_range(0, 2) == 0) begin
					line_q.push_back(CH_4);
				end else begin
					do
						c = 8'($urandom_range(0, 255));
					while (c >= CH_0 && c <= CH_9);
					line_q.push_back(c);
				end
			end else begin
				do
					c = 8'($urandom_range(0, 255));
				while (c == CH_S);
				line_q.push_back(c);
				line_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
			end
		end else begin
			repeat ($urandom_range(1, 6))
				line_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_char(input logic [7:0] c, input bit typed, input parse_event_t typed_ev);
		parse_event_t ev;
		bit hit;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) :
				$urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		ascii_char <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		hit = predict_char(c, ev);
		if (typed)
			event_q.push_back(typed_ev);
		else if (hit)
			event_q.push_back(ev);
		chars_sent++;
		burst_left--;
	endtask

	task automatic drain_results();
		int unsigned waited;
		in_valid <= 1'b0;
		waited = 0;
		while (event_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] max_count, input logic [1:0] trailer);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_MAX_COUNT;
		cfg_data <= max_count;
		@(posedge clk);
		cfg_index <= REG_TRAILER_CHARS;
		cfg_data <= {6'($urandom_range(0, 63)), trailer};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_max_count = max_count;
		cfg_trailer = trailer;
		settings_used++;
	endtask

	task automatic run_random(input int unsigned budget);
		int unsigned sent;
		sent = 0;
		while (sent < budget) begin
			build_record();
			while (line_q.size() != 0) begin
				send_char(line_q.pop_front(), 1'b0, '0);
				sent++;
			end
		end
		drain_results();
	endtask

	task automatic report_mismatch(input string what, input parse_event_t want,
			input parse_event_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected kind=%0d type=%0d count=%0d addr=%h chars=%0d data=%h bad=%0d,",
				what, want.kind, want.rtype, want.count, want.addr, want.achars, want.data,
				want.bad, " got kind=%0d type=%0d count=%0d addr=%h chars=%0d data=%h bad=%0d",
				got.kind, got.rtype, got.count, got.addr, got.achars, got.data, got.bad);
	endtask

	always @(posedge clk) begin : result_side
		parse_event_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{event_kind, record_type, byte_count, load_address, address_chars,
				data_value, bad_hex};
			if (event_q.size() == 0) begin
				report_mismatch("unexpected event", '0, got);
			end else begin
				want = event_q.pop_front();
				events_seen++;
				if (got !== want)
					report_mismatch("event mismatch", want, got);
			end
		end
		// receiver alternates between free flow, light and heavy stalls
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(16, 200);
		end
		rx_left--;
		case (rx_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ($urandom_range(0, 3) != 0);
			2:       out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((rx_left % 5) < 2);
		endcase
	end

	initial begin : stimulus
		string text;
		int i;
		text = "S4X1S100S103FFfFZb\015\012";
		for (i = 0; i < 20; i++)
			dir_rows[i] = '{text[i], 1'b0, '0};
		dir_rows[1].typed = 1'b1;
		dir_rows[1].ev = mk_ev(EV_TYPE_ERR, 4'd0, 8'd0, 32'd0, 4'd0, 8'd0, 1'b0);
		dir_rows[3].typed = 1'b1;
		dir_rows[3].ev = mk_ev(EV_TYPE_ERR, 4'd0, 8'd0, 32'd0, 4'd0, 8'd0, 1'b0);
		dir_rows[7].typed = 1'b1;
		dir_rows[7].ev = mk_ev(EV_COUNT_ERR, 4'd1, 8'd0, 32'd0, 4'd4, 8'd0, 1'b0);
		dir_rows[15].typed = 1'b1;
		dir_rows[15].ev = mk_ev(EV_HEADER, 4'd1, 8'd3, 32'h0000FFFF, 4'd4, 8'd0, 1'b0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k])
			send_char(dir_rows[k].ch, dir_rows[k].typed, dir_rows[k].ev);
		run_random(300);

		set_config(8'd3, 2'd0);
		run_random(250);
		set_config(8'd0, 2'd3);
		run_random(80);
		set_config(8'd255, 2'd3);
		run_random(300);
		set_config(8'd1, 2'd1);
		run_random(80);
		set_config(8'd40, 2'd0);
		run_random(300);
		set_config(8'd255, 2'd2);
		run_random(400);

		$display("sent %0d characters in %0d generated records, checked %0d events",
			chars_sent, records_built, events_seen);
		$display("%0d register settings applied, %0d mismatches, %0d events never seen",
			settings_used, mismatches, event_q.size());
		if (mismatches == 0 && event_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("FAILURE");
		$finish;
	end

endmodule
